/* rtl/opm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Opcode pattern match table package
// Shared constants, payload types, control types and match functions.
// ----------------------------------------------------------------------------
package opm_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W       = 9;
    localparam int BYTE_W      = 8;
    localparam int ENTRY_W     = 7 * BYTE_W;

    localparam logic [BYTE_W-1:0] NULL_CODE = 8'hFF;
    localparam logic [BYTE_W-1:0] MEM_MOD   = 8'h6D;
    localparam logic [BYTE_W-1:0] REG_MOD   = 8'h03;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] entry_index;
        logic [BYTE_W-1:0] map_sel;
        logic [BYTE_W-1:0] prefix_byte;
        logic [BYTE_W-1:0] opcode_byte;
        logic [BYTE_W-1:0] mod_value;
        logic [BYTE_W-1:0] reg_value;
        logic [BYTE_W-1:0] rm_value;
        logic [BYTE_W-1:0] opcode_bit_count;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [BYTE_W-1:0] match_index;
    } t_out_item;

    typedef struct packed {
        logic [BYTE_W-1:0] map_sel;
        logic [BYTE_W-1:0] prefix;
        logic [BYTE_W-1:0] opcode;
        logic [BYTE_W-1:0] mod_v;
        logic [BYTE_W-1:0] reg_v;
        logic [BYTE_W-1:0] rm_v;
        logic [BYTE_W-1:0] bit_count;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic load_wr;
        logic capture;
        logic scan;
        logic res_hit;
        logic res_clear;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic scan_end;
    } t_dp_stat;

    function automatic logic [BYTE_W-1:0] top_mask(input logic [BYTE_W-1:0] bits);
        logic [BYTE_W-1:0] mask;
        if (bits >= 8'd8) begin
            mask = 8'hFF;
        end else begin
            mask = 8'hFF << (4'd8 - 4'(bits));
        end
        return mask;
    endfunction

    function automatic logic entry_match(input t_entry e, input t_in_item k);
        logic ok;
        ok = (k.map_sel == e.map_sel);
        if (e.bit_count == NULL_CODE) begin
            ok = ok && (k.opcode_byte == e.opcode);
        end else begin
            ok = ok && ((k.opcode_byte & top_mask(e.bit_count)) == e.opcode);
        end
        if (k.prefix_byte != NULL_CODE) begin
            ok = ok && (k.prefix_byte == e.prefix);
        end
        if (k.mod_value != NULL_CODE) begin
            if (e.mod_v == MEM_MOD) begin
                ok = ok && (k.mod_value != REG_MOD);
            end else begin
                ok = ok && (k.mod_value == e.mod_v);
            end
        end
        if (k.reg_value != NULL_CODE) begin
            ok = ok && (k.reg_value == e.reg_v);
        end
        if (k.rm_value != NULL_CODE) begin
            ok = ok && (k.rm_value == e.rm_v);
        end
        return ok;
    endfunction

endpackage

/* rtl/opm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Opcode pattern match table channels
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface opm_in_if;
    logic               valid;
    logic               ready;
    opm_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface opm_out_if;
    logic               valid;
    logic               ready;
    opm_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/opcode_pattern_match_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Opcode pattern match table
// Stores decode patterns and returns the first entry matching a lookup.
//
// Input items arrive on i_in and results leave on o_out, both valid/ready
// channels; a transfer happens on a clock edge with valid and ready high.
// Every item gives exactly one result. A load writes one table entry and
// returns found = 0; its result goes through the hold state to the output
// register. A lookup scans entries from 0 upward, one per cycle through the
// pattern memory read port, and stops at the first match.
// One item is in work at a time; the block returns to idle, where it takes
// the next one, when the result moves to the output register.
// The output register holds a result while the receiver stalls, and the
// block can take and process the next item during that time.
// The entry count is written through i_cfg_we and i_cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// Reset clears the entry count and the control state. The pattern memory is
// not cleared; entries read before being loaded give undefined matches.
// ----------------------------------------------------------------------------
module opcode_pattern_match_table_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    opm_in_if.sink                    i_in,
    opm_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [opm_pkg::CFG_W-1:0] i_cfg_wdata
);

    opm_pkg::t_dp_cmd  cmd;
    opm_pkg::t_dp_stat stat;

    opm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_op       (i_in.data.op),
        .o_in_ready (i_in.ready),
        .i_out_ready(o_out.ready),
        .o_out_valid(o_out.valid),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    opm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_item     (i_in.data),
        .o_res      (o_out.data)
    );

endmodule

/* rtl/opm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module opm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/opm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Opcode pattern match table controller
// Sequences loads, table scans and the hand-off to the output register.
// ----------------------------------------------------------------------------
module opm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_op,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output opm_pkg::t_dp_cmd  o_cmd,
    input  opm_pkg::t_dp_stat i_stat
);

    opm_pkg::t_state r_state;
    opm_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            opm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_op == opm_pkg::OP_LOOKUP) ? opm_pkg::S_SCAN : opm_pkg::S_HOLD;
                end
            end
            opm_pkg::S_SCAN: begin
                if (i_stat.hit || i_stat.scan_end) begin
                    n_state = opm_pkg::S_HOLD;
                end
            end
            opm_pkg::S_HOLD: begin
                if (slot_free) begin
                    n_state = opm_pkg::S_IDLE;
                end
            end
            default: n_state = opm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            opm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_op == opm_pkg::OP_LOAD) begin
                        o_cmd.load_wr   = 1'b1;
                        o_cmd.res_clear = 1'b1;
                    end
                end
            end
            opm_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.res_hit = 1'b1;
                end else if (i_stat.scan_end) begin
                    o_cmd.res_clear = 1'b1;
                end
            end
            opm_pkg::S_HOLD: begin
                o_cmd.push = slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= opm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/opm_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Opcode pattern match table datapath
// Pattern memory, entry count, scan address counter, compare and result.
// ----------------------------------------------------------------------------
module opm_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  opm_pkg::t_dp_cmd           i_cmd,
    output opm_pkg::t_dp_stat          o_stat,
    input  logic                       i_cfg_we,
    input  logic [opm_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  opm_pkg::t_in_item          i_item,
    output opm_pkg::t_out_item         o_res
);

    logic [opm_pkg::CNT_W-1:0]   r_count;
    logic [opm_pkg::CNT_W-1:0]   n_count;
    logic [opm_pkg::CNT_W-1:0]   r_addr;
    logic [opm_pkg::CNT_W-1:0]   n_addr;
    logic                        r_cmp_valid;
    logic                        n_cmp_valid;
    logic [opm_pkg::ADDR_W-1:0]  r_cmp_idx;
    opm_pkg::t_in_item           r_key;
    opm_pkg::t_out_item          r_res;
    opm_pkg::t_out_item          r_out;
    opm_pkg::t_entry             wr_entry;
    opm_pkg::t_entry             rd_entry;
    logic [opm_pkg::ENTRY_W-1:0] rd_data;
    logic                        wr_en;
    logic                        more;
    logic                        issue;

    assign wr_en = i_cmd.load_wr
                   && (32'(i_item.entry_index) < 32'(opm_pkg::TABLE_DEPTH));

    assign wr_entry = '{
        map_sel:   i_item.map_sel,
        prefix:    i_item.prefix_byte,
        opcode:    i_item.opcode_byte,
        mod_v:     i_item.mod_value,
        reg_v:     i_item.reg_value,
        rm_v:      i_item.rm_value,
        bit_count: i_item.opcode_bit_count
    };

    opm_ram #(
        .WIDTH(opm_pkg::ENTRY_W),
        .DEPTH(opm_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(opm_pkg::ADDR_W'(i_item.entry_index)),
        .i_wdata(wr_entry),
        .i_raddr(r_addr[opm_pkg::ADDR_W-1:0]),
        .o_rdata(rd_data)
    );

    assign rd_entry = rd_data;
    assign more     = (r_addr < r_count);
    assign issue    = i_cmd.scan && more;

    assign o_stat.hit      = r_cmp_valid && opm_pkg::entry_match(rd_entry, r_key);
    assign o_stat.scan_end = !r_cmp_valid && !more;

    always_comb begin
        if (32'(i_cfg_wdata) > 32'(opm_pkg::TABLE_DEPTH)) begin
            n_count = opm_pkg::CNT_W'(opm_pkg::TABLE_DEPTH);
        end else begin
            n_count = opm_pkg::CNT_W'(i_cfg_wdata);
        end
    end

    always_comb begin
        n_addr      = r_addr;
        n_cmp_valid = r_cmp_valid;
        if (i_cmd.capture) begin
            n_addr      = '0;
            n_cmp_valid = 1'b0;
        end else if (i_cmd.scan) begin
            n_addr      = issue ? r_addr + 1'b1 : r_addr;
            n_cmp_valid = issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_addr      <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= n_count;
            end
            r_addr      <= n_addr;
            r_cmp_valid <= n_cmp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key <= i_item;
        end
        if (issue) begin
            r_cmp_idx <= r_addr[opm_pkg::ADDR_W-1:0];
        end
        if (i_cmd.res_hit) begin
            r_res.found       <= 1'b1;
            r_res.match_index <= opm_pkg::BYTE_W'(r_cmp_idx);
        end else if (i_cmd.res_clear) begin
            r_res <= '0;
        end
        if (i_cmd.push) begin
            r_out <= r_res;
        end
    end

    assign o_res = r_out;

endmodule

/* rtl/opm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Opcode pattern match table checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module opm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_found,
    input logic [opm_pkg::BYTE_W-1:0]  i_match_index
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_found)
        && $stable(i_match_index))
        else $error("Stalled result changed or dropped.");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> i_match_index == '0)
        else $error("Result without a match carries a nonzero index.");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Second transfer taken while an item is in work.");

    a_reset_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("Result valid right after reset.");

endmodule

bind opcode_pattern_match_table_top opm_checker u_opm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_found      (o_out.data.found),
    .i_match_index(o_out.data.match_index)
);
